// File: src/fixed_point_radix2_fft_unit_macros.svh
// ----------------------------------------------------------------------------
// FFT unit assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_RADIX2_FFT_UNIT_MACROS_SVH
`define FIXED_POINT_RADIX2_FFT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define FPFFT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("fft unit check failed");

// Consequent must hold in the cycle after the antecedent
`define FPFFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("fft unit check failed");

`endif

// File: src/fpfft_pkg.sv
// ----------------------------------------------------------------------------
// FFT unit package
// Payload types, queue item type, fixed-point helpers and rotation ROM.
// ----------------------------------------------------------------------------
package fpfft_pkg;

	localparam int FRAC_BITS = 30;
	localparam int LG_W      = 5;
	localparam int IDX_W     = 10;
	localparam logic signed [31:0] Q_ONE = 32'sd1073741824;

	typedef struct packed {
		logic signed [31:0] sample_real;
		logic signed [31:0] sample_imag;
	} fpfft_in_t;

	typedef struct packed {
		logic signed [31:0] bin_real;
		logic signed [31:0] bin_imag;
		logic [IDX_W-1:0]   bin_index;
		logic               bin_valid;
	} fpfft_out_t;

	// One classified sample on its way to the back end
	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [LG_W-1:0]    lg;
		logic               first;
		logic               last;
	} fpfft_item_t;

	// Rotation constants per stage, cos and sin of -2*pi/2^s in Q2.30
	localparam logic signed [31:0] ROT_COS [17] = '{
		32'sd0, -32'sd1073741824, -32'sd46, 32'sd759250112, 32'sd992008064,
		32'sd1053110144, 32'sd1068571456, 32'sd1072448448, 32'sd1073418432,
		32'sd1073660992, 32'sd1073721600, 32'sd1073736768, 32'sd1073740544,
		32'sd1073741504, 32'sd1073741760, 32'sd1073741824, 32'sd1073741824
	};
	localparam logic signed [31:0] ROT_SIN [17] = '{
		32'sd0, 32'sd0, -32'sd1073741824, -32'sd759250112, -32'sd410903232,
		-32'sd209476640, -32'sd105245104, -32'sd52686012, -32'sd26350942,
		-32'sd13176463, -32'sd6588355, -32'sd3294192, -32'sd1647098,
		-32'sd823548, -32'sd411774, -32'sd205887, -32'sd102943
	};

	// Full signed 32 x 32 product
	function automatic logic signed [63:0] mul64(logic signed [31:0] a,
	                                             logic signed [31:0] b);
		logic signed [63:0] ax;
		logic signed [63:0] bx;
		ax = 64'(a);
		bx = 64'(b);
		return ax * bx;
	endfunction

	// Arithmetic shift back to Q2.30, kept to 32 bits
	function automatic logic signed [31:0] shift_q(logic signed [63:0] v);
		logic signed [63:0] r;
		r = v >>> FRAC_BITS;
		return r[31:0];
	endfunction

endpackage

// File: src/fixed_point_radix2_fft_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point radix-2 FFT unit
// Frame-based in-place DIT FFT on complex Q2.30 samples, double-buffered.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on in_valid / in_stall / in_data; each transfer returns one
// bin on out_valid / out_stall / out_data: the bin of the previous completed
// frame with the same index, flagged bin_valid = 0 during the first frame.
// cfg_wr_en / cfg_wr_data write the length register (log2 of points); a
// write discards the partial frame and the stored spectrum.
// A sample is written into the queue, taken into the back end and its bin
// registered on out_data. The back end takes a new sample only after it has
// returned the bin of the last, as the spectrum read is registered. After the
// last sample of a frame the back end runs the transform: a bit-reversal copy
// of the frame into the spectrum store, then (N/2) * log2(N) butterflies, each
// stepping through the states RD, MB, MW, WA and WB in turn, as set by the
// single memory write port and the shared complex multiplier. A two-entry
// queue keeps accepting meanwhile.
// Reset clears control state and selects 1024 points; the stores need no
// clearing. A stalled receiver holds the output register and, once the
// queue fills, raises in_stall.
// ----------------------------------------------------------------------------
module fixed_point_radix2_fft_unit #(
	parameter int MAX_LOG2_POINTS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [3:0]             cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  fpfft_pkg::fpfft_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output fpfft_pkg::fpfft_out_t  out_data
);
	import fpfft_pkg::*;

	logic        q_valid;
	logic        q_pop;
	fpfft_item_t q_item;

	// Classify and queue samples
	fpfft_front #(.MAX_LOG2_POINTS(MAX_LOG2_POINTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item)
	);

	// Store, return bins and transform
	fpfft_engine #(.MAX_LOG2_POINTS(MAX_LOG2_POINTS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: src/fpfft_front.sv
// ----------------------------------------------------------------------------
// FFT unit front end
// Accepts samples, tags frame position flags and queues them for the back end.
// ----------------------------------------------------------------------------
module fpfft_front #(
	parameter int MAX_LOG2_POINTS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [3:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fpfft_pkg::fpfft_in_t in_data,
	output logic                 q_valid,
	input  logic                 q_pop,
	output fpfft_pkg::fpfft_item_t q_item
);
	import fpfft_pkg::*;

	localparam int AW = MAX_LOG2_POINTS;

	logic [3:0]      points_q;
	logic [AW-1:0]   count_q;
	logic            have_q;
	fpfft_item_t     fifo_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	logic [LG_W-1:0] lg_eff;
	logic [AW-1:0]   last_pos;
	logic            push;
	logic            is_last;
	fpfft_item_t     new_item;

	// Clamp the length register into the supported range
	always_comb begin
		lg_eff = LG_W'(points_q);
		if (lg_eff == '0)
			lg_eff = LG_W'(1);
		if (lg_eff > LG_W'(AW))
			lg_eff = LG_W'(AW);
		last_pos = {AW{1'b1}} >> (AW - int'(lg_eff));
		is_last  = (count_q == last_pos);
		new_item.re    = in_data.sample_real;
		new_item.im    = in_data.sample_imag;
		new_item.lg    = lg_eff;
		new_item.first = !have_q;
		new_item.last  = is_last;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rp_q];

	// Track frame position and queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= 4'd10;
			count_q  <= '0;
			have_q   <= 1'b0;
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_wr_en) begin
				points_q <= cfg_wr_data;
				count_q  <= '0;
				have_q   <= 1'b0;
			end else if (push) begin
				if (is_last) begin
					count_q <= '0;
					have_q  <= 1'b1;
				end else begin
					count_q <= count_q + AW'(1);
				end
			end
			if (push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= new_item;
	end

endmodule

// File: src/fpfft_engine.sv
// ----------------------------------------------------------------------------
// FFT unit back end
// Stores samples, returns bins and runs the in-place transform per frame.
// ----------------------------------------------------------------------------
module fpfft_engine #(
	parameter int MAX_LOG2_POINTS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  fpfft_pkg::fpfft_item_t q_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output fpfft_pkg::fpfft_out_t  out_data
);
	import fpfft_pkg::*;

	`include "fixed_point_radix2_fft_unit_macros.svh"

	localparam int AW = MAX_LOG2_POINTS;
	localparam int N  = 1 << AW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RESP, ST_BR, ST_RD, ST_MB, ST_MW, ST_WA, ST_WB
	} state_t;

	state_t             state_q;
	fpfft_item_t        item_q;
	logic [AW-1:0]      pos_q;
	logic [AW:0]        br_cnt_q;
	logic [LG_W-1:0]    s_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      j_q;
	logic signed [31:0] w_re_q, w_im_q;
	logic signed [31:0] t_re_q, t_im_q;
	logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic               out_valid_q;
	fpfft_out_t         out_q;

	logic [63:0]        work_mem [N];
	logic [63:0]        spec_mem [N];
	logic [63:0]        wrd_q;
	logic [63:0]        rda_q, rdb_q;

	logic               out_free;
	logic [AW:0]        n_full, step, half, i_next;
	logic [AW-1:0]      k, kh, half_m1;
	logic [AW-1:0]      spec_ra;
	logic               ren_a, ren_b, spec_we;
	logic [AW-1:0]      spec_wa;
	logic [63:0]        spec_wd;
	logic signed [31:0] opb_re, opb_im;
	logic signed [31:0] a_re, a_im;
	logic [AW+IDX_W-1:0] idx_ext;

	// Reverse the low lg bits of an address
	function automatic logic [AW-1:0] rev_addr(logic [AW-1:0] x, logic [LG_W-1:0] lg);
		logic [AW-1:0] r;
		for (int b = 0; b < AW; b++)
			r[AW-1-b] = x[b];
		return r >> (AW - int'(lg));
	endfunction

	// Butterfly addressing
	always_comb begin
		n_full  = (AW+1)'(1) << item_q.lg;
		step    = (AW+1)'(1) << s_q;
		half    = step >> 1;
		half_m1 = half[AW-1:0] - AW'(1);
		k       = i_q + j_q;
		kh      = k + half[AW-1:0];
		i_next  = {1'b0, i_q} + step;
		a_re    = rda_q[31:0];
		a_im    = rda_q[63:32];
		idx_ext = {{IDX_W{1'b0}}, pos_q};
	end

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = q_valid && (state_q == ST_IDLE) && out_free;

	// Memory port control
	always_comb begin
		ren_a   = q_pop || (state_q == ST_RD);
		ren_b   = (state_q == ST_RD);
		spec_ra = (state_q == ST_RD) ? k : pos_q;
		spec_we = 1'b0;
		spec_wa = k;
		spec_wd = {a_im + t_im_q, a_re + t_re_q};
		case (state_q)
			ST_BR: begin
				spec_we = (br_cnt_q != '0);
				spec_wa = rev_addr(AW'(br_cnt_q - (AW+1)'(1)), item_q.lg);
				spec_wd = wrd_q;
			end
			ST_WA: begin
				spec_we = 1'b1;
			end
			ST_WB: begin
				spec_we = 1'b1;
				spec_wa = kh;
				spec_wd = {a_im - t_im_q, a_re - t_re_q};
			end
			default: begin
				spec_we = 1'b0;
			end
		endcase
		if (state_q == ST_MB) begin
			opb_re = rdb_q[31:0];
			opb_im = rdb_q[63:32];
		end else begin
			opb_re = ROT_COS[s_q];
			opb_im = ROT_SIN[s_q];
		end
	end

	// Sample store: written per transfer, swept for the bit reversal
	always_ff @(posedge clk) begin
		if (q_pop)
			work_mem[pos_q] <= {q_item.im, q_item.re};
		if (state_q == ST_BR && br_cnt_q < n_full)
			wrd_q <= work_mem[br_cnt_q[AW-1:0]];
	end

	// Spectrum store, transformed in place
	always_ff @(posedge clk) begin
		if (spec_we)
			spec_mem[spec_wa] <= spec_wd;
		if (ren_a)
			rda_q <= spec_mem[spec_ra];
		if (ren_b)
			rdb_q <= spec_mem[kh];
	end

	// Shared complex multiplier, four parallel products
	always_ff @(posedge clk) begin
		p_rr_q <= mul64(w_re_q, opb_re);
		p_ii_q <= mul64(w_im_q, opb_im);
		p_ri_q <= mul64(w_re_q, opb_im);
		p_ir_q <= mul64(w_im_q, opb_re);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			br_cnt_q    <= '0;
			s_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			w_re_q      <= Q_ONE;
			w_im_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_wr_en)
				pos_q <= '0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						item_q  <= q_item;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					out_valid_q        <= 1'b1;
					out_q.bin_real     <= item_q.first ? '0 : a_re;
					out_q.bin_imag     <= item_q.first ? '0 : a_im;
					out_q.bin_valid    <= !item_q.first;
					out_q.bin_index    <= idx_ext[IDX_W-1:0];
					if (item_q.last) begin
						pos_q    <= '0;
						br_cnt_q <= '0;
						state_q  <= ST_BR;
					end else begin
						pos_q   <= pos_q + AW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_BR: begin
					if (br_cnt_q == n_full) begin
						s_q     <= LG_W'(1);
						i_q     <= '0;
						j_q     <= '0;
						w_re_q  <= Q_ONE;
						w_im_q  <= '0;
						state_q <= ST_RD;
					end else begin
						br_cnt_q <= br_cnt_q + (AW+1)'(1);
					end
				end
				ST_RD: state_q <= ST_MB;
				ST_MB: state_q <= ST_MW;
				ST_MW: begin
					t_re_q  <= shift_q(p_rr_q - p_ii_q);
					t_im_q  <= shift_q(p_ri_q + p_ir_q);
					state_q <= ST_WA;
				end
				ST_WA: begin
					w_re_q  <= shift_q(p_rr_q - p_ii_q);
					w_im_q  <= shift_q(p_ri_q + p_ir_q);
					state_q <= ST_WB;
				end
				ST_WB: begin
					state_q <= ST_RD;
					if (j_q == half_m1) begin
						j_q    <= '0;
						w_re_q <= Q_ONE;
						w_im_q <= '0;
						if (i_next == n_full) begin
							i_q <= '0;
							if (s_q == item_q.lg)
								state_q <= ST_IDLE;
							else
								s_q <= s_q + LG_W'(1);
						end else begin
							i_q <= i_next[AW-1:0];
						end
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`FPFFT_ASSERT_NEXT(a_last_starts_br, state_q == ST_RESP && item_q.last, state_q == ST_BR && br_cnt_q == '0)
	`FPFFT_ASSERT_SAME(a_resp_slot_free, state_q == ST_RESP, !out_valid_q)
	`FPFFT_ASSERT_SAME(a_twiddle_start, state_q == ST_RD && j_q == '0, w_re_q == Q_ONE && w_im_q == '0)

endmodule
